// ===== rtl/biq_pkg.sv =====
// Shared types and constants for the multichannel biquad filter.
// No dependencies; used by biq_mac, biq_div and the top level.
package biq_pkg;

	localparam int COEF_W = 20;              // Q3.16 signed coefficient width
	localparam int NORM_W = 19;              // Q3.16 unsigned normalizer width
	localparam int DIGITS = COEF_W / 2;      // radix-4 digits per coefficient
	localparam int DIG_W  = $clog2(DIGITS);

	// Product terms of the sum, in the order the MAC walks them.
	typedef enum logic [2:0] {
		TERM_B0 = 3'd0,
		TERM_B1 = 3'd1,
		TERM_B2 = 3'd2,
		TERM_A1 = 3'd3,
		TERM_A2 = 3'd4
	} term_t;

endpackage

// ===== rtl/biq_mac.sv =====
// Digit-serial multiply-accumulate over the five biquad terms.
// Radix-4 Booth recoding, two coefficient bits per cycle; uses biq_pkg.
module biq_mac #(
	parameter int ACC_W = 47
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [ACC_W-1:0]           mcand,
	input  logic signed [biq_pkg::COEF_W-1:0] coef,
	output biq_pkg::term_t                    term,
	output logic signed [ACC_W-1:0]           acc,
	output logic                              done
);

	typedef enum logic [1:0] {M_IDLE, M_LOAD, M_RUN} mac_state_t;

	mac_state_t                        state_q;
	biq_pkg::term_t                    term_q;
	logic [biq_pkg::DIG_W-1:0]         dig_q;
	logic signed [ACC_W-1:0]           mcand_q;
	logic signed [biq_pkg::COEF_W-1:0] coef_q;
	logic                              prev_q;
	logic signed [ACC_W-1:0]           acc_q;
	logic                              done_q;
	logic signed [ACC_W-1:0]           addend;

	// Booth digit from the two low coefficient bits and the bit shifted out last
	always_comb begin
		unique case ({coef_q[1:0], prev_q})
			3'b000, 3'b111: addend = '0;
			3'b001, 3'b010: addend = mcand_q;
			3'b011:         addend = mcand_q <<< 1;
			3'b100:         addend = -(mcand_q <<< 1);
			3'b101, 3'b110: addend = -mcand_q;
			default:        addend = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			term_q  <= biq_pkg::TERM_B0;
			dig_q   <= '0;
			mcand_q <= '0;
			coef_q  <= '0;
			prev_q  <= 1'b0;
			acc_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						acc_q   <= '0;
						term_q  <= biq_pkg::TERM_B0;
						state_q <= M_LOAD;
					end
				end
				M_LOAD: begin
					mcand_q <= mcand;
					coef_q  <= coef;
					prev_q  <= 1'b0;
					dig_q   <= '0;
					state_q <= M_RUN;
				end
				M_RUN: begin
					acc_q   <= acc_q + addend;
					mcand_q <= mcand_q <<< 2;
					coef_q  <= {{2{coef_q[biq_pkg::COEF_W-1]}}, coef_q[biq_pkg::COEF_W-1:2]};
					prev_q  <= coef_q[1];
					dig_q   <= dig_q + 1'b1;
					if (dig_q == biq_pkg::DIG_W'(biq_pkg::DIGITS - 1)) begin
						if (term_q == biq_pkg::TERM_A2) begin
							done_q  <= 1'b1;
							state_q <= M_IDLE;
						end else begin
							term_q  <= biq_pkg::term_t'(term_q + 3'd1);
							state_q <= M_LOAD;
						end
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign term = term_q;
	assign acc  = acc_q;
	assign done = done_q;

endmodule

// ===== rtl/biq_div.sv =====
// Bit-serial restoring divider with truncation toward zero and saturation
// to the sample range. Uses biq_pkg for the normalizer width.
module biq_div #(
	parameter int ACC_W       = 47,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [ACC_W-1:0]           acc,
	input  logic [biq_pkg::NORM_W-1:0]        norm,
	output logic [SAMPLE_BITS-1:0]            quot,
	output logic                              clip,
	output logic                              done
);

	localparam int NW    = biq_pkg::NORM_W;
	localparam int HI_W  = ACC_W - SAMPLE_BITS;
	localparam int CNT_W = $clog2(SAMPLE_BITS);

	typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN, D_SAT} div_state_t;

	div_state_t              state_q;
	logic                    neg_q;
	logic [ACC_W-1:0]        mag_q;
	logic [NW-1:0]           den_q;
	logic [NW-1:0]           rem_q;
	logic [SAMPLE_BITS-1:0]  low_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SAMPLE_BITS-1:0]  quot_q;
	logic                    clip_q;
	logic                    done_q;

	logic [NW:0]             trial;
	logic                    fits;
	logic                    ovf;
	logic [SAMPLE_BITS-1:0]  max_pos;
	logic [SAMPLE_BITS-1:0]  max_neg;

	assign trial   = {rem_q, low_q[SAMPLE_BITS-1]};
	assign fits    = trial >= {1'b0, den_q};
	assign ovf     = mag_q[ACC_W-1:SAMPLE_BITS] >= HI_W'(den_q);
	assign max_pos = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	assign max_neg = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			den_q   <= '0;
			rem_q   <= '0;
			low_q   <= '0;
			cnt_q   <= '0;
			quot_q  <= '0;
			clip_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						neg_q   <= acc[ACC_W-1];
						mag_q   <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
						// a zero normalizer acts as one
						den_q   <= (norm == '0) ? NW'(1) : norm;
						state_q <= D_CHECK;
					end
				end
				D_CHECK: begin
					if (ovf) begin
						// quotient magnitude reaches 2^SAMPLE_BITS: clip at once
						quot_q  <= neg_q ? max_neg : max_pos;
						clip_q  <= 1'b1;
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						// high part is below the divisor, so it is the running remainder
						rem_q   <= mag_q[NW-1+SAMPLE_BITS:SAMPLE_BITS];
						low_q   <= mag_q[SAMPLE_BITS-1:0];
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					// dividend bits leave at the top, quotient bits enter at the bottom
					rem_q <= fits ? NW'(trial - {1'b0, den_q}) : trial[NW-1:0];
					low_q <= {low_q[SAMPLE_BITS-2:0], fits};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SAMPLE_BITS - 1))
						state_q <= D_SAT;
				end
				D_SAT: begin
					if (!neg_q) begin
						clip_q <= low_q[SAMPLE_BITS-1];
						quot_q <= low_q[SAMPLE_BITS-1] ? max_pos : low_q;
					end else begin
						clip_q <= low_q[SAMPLE_BITS-1] & (|low_q[SAMPLE_BITS-2:0]);
						quot_q <= (low_q[SAMPLE_BITS-1] & (|low_q[SAMPLE_BITS-2:0]))
							? max_neg : SAMPLE_BITS'(-low_q);
					end
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign quot = quot_q;
	assign clip = clip_q;
	assign done = done_q;

endmodule

// ===== rtl/multichannel_iir_biquad_df1_unit.sv =====
// Multichannel direct form I biquad: y = (b0*x0 + b1*x1 + b2*x2 - a1*y1 - a2*y2) / a0.
// A quotient that overflows is clipped at once, without the bit-serial divide steps. One
// sample at a time; the next input can be taken the cycle after the result enters the
// output register. The timing is set by the radix-4 Booth MAC and the bit-serial divider.
// Reset (arst_n low) clears all histories, loads b0 = a0 = 1.0 and other coefficients 0.
module multichannel_iir_biquad_df1_unit #(
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input samples
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // sample_in
	input  logic                                s_tuser,   // chan
	// filtered samples
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // sample_out, zero padded
	output logic                                m_tuser,   // clipped
	// coefficient writes
	input  logic                                cfg_wr_en,
	input  logic [2:0]                          cfg_addr,
	input  logic [biq_pkg::COEF_W-1:0]          cfg_wdata
);

	localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int ACC_W  = SAMPLE_BITS + 23;   // five Q(SB+3).16 products, exact
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CW     = biq_pkg::COEF_W;
	localparam int NW     = biq_pkg::NORM_W;

	localparam logic [2:0] REG_FF0  = 3'd0;
	localparam logic [2:0] REG_FF1  = 3'd1;
	localparam logic [2:0] REG_FF2  = 3'd2;
	localparam logic [2:0] REG_NORM = 3'd3;
	localparam logic [2:0] REG_FB1  = 3'd4;
	localparam logic [2:0] REG_FB2  = 3'd5;

	typedef enum logic [1:0] {T_IDLE, T_MAC, T_DIV, T_WB} top_state_t;

	// coefficient registers
	logic signed [CW-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [NW-1:0]        a0_q;

	// per-channel history, newest and older
	logic signed [SAMPLE_BITS-1:0] xh1_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] xh2_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] yh1_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] yh2_q [CHANNELS];

	top_state_t                    state_q;
	logic signed [SAMPLE_BITS-1:0] x0_q;
	logic [CH_W-1:0]               ch_q;
	logic                          m_valid_q;
	logic [SAMPLE_BITS-1:0]        m_data_q;
	logic                          m_clip_q;

	logic                          in_take;
	logic                          out_free;
	logic                          out_load;
	logic [CH_W-1:0]               ch_sel;

	biq_pkg::term_t                term;
	logic signed [ACC_W-1:0]       mcand;
	logic signed [CW-1:0]          coef;
	logic signed [ACC_W-1:0]       acc;
	logic                          mac_done;
	logic [SAMPLE_BITS-1:0]        quot;
	logic                          clip;
	logic                          div_done;

	assign s_tready = (state_q == T_IDLE);
	assign in_take  = s_tvalid & s_tready;
	assign out_free = ~m_valid_q | m_tready;
	assign out_load = (state_q == T_WB) & out_free;
	// channel number taken modulo CHANNELS; a 1-bit channel only folds at one channel
	assign ch_sel   = (CHANNELS > 1) ? CH_W'(s_tuser) : '0;

	// Pick operand pair for the term the MAC is on; feedback terms use negated history
	always_comb begin
		unique case (term)
			biq_pkg::TERM_B0: begin
				mcand = ACC_W'(x0_q);
				coef  = b0_q;
			end
			biq_pkg::TERM_B1: begin
				mcand = ACC_W'(xh1_q[ch_q]);
				coef  = b1_q;
			end
			biq_pkg::TERM_B2: begin
				mcand = ACC_W'(xh2_q[ch_q]);
				coef  = b2_q;
			end
			biq_pkg::TERM_A1: begin
				mcand = -ACC_W'(yh1_q[ch_q]);
				coef  = a1_q;
			end
			biq_pkg::TERM_A2: begin
				mcand = -ACC_W'(yh2_q[ch_q]);
				coef  = a2_q;
			end
			default: begin
				mcand = '0;
				coef  = '0;
			end
		endcase
	end

	biq_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_take),
		.mcand  (mcand),
		.coef   (coef),
		.term   (term),
		.acc    (acc),
		.done   (mac_done)
	);

	biq_div #(
		.ACC_W       (ACC_W),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_done),
		.acc    (acc),
		.norm   (a0_q),
		.quot   (quot),
		.clip   (clip),
		.done   (div_done)
	);

	// Coefficient writes; indexes past the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= CW'(65536);
			b1_q <= '0;
			b2_q <= '0;
			a0_q <= NW'(65536);
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_FF0:  b0_q <= cfg_wdata;
				REG_FF1:  b1_q <= cfg_wdata;
				REG_FF2:  b2_q <= cfg_wdata;
				REG_NORM: a0_q <= cfg_wdata[NW-1:0];
				REG_FB1:  a1_q <= cfg_wdata;
				REG_FB2:  a2_q <= cfg_wdata;
				default:  ;
			endcase
		end
	end

	// Advance the channel's history when its result enters the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				xh1_q[i] <= '0;
				xh2_q[i] <= '0;
				yh1_q[i] <= '0;
				yh2_q[i] <= '0;
			end
		end else if (out_load) begin
			xh2_q[ch_q] <= xh1_q[ch_q];
			xh1_q[ch_q] <= x0_q;
			yh2_q[ch_q] <= yh1_q[ch_q];
			yh1_q[ch_q] <= quot;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			x0_q      <= '0;
			ch_q      <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_clip_q  <= 1'b0;
		end else begin
			// drop valid once taken, unless a new result loads in the same cycle
			if (m_valid_q && m_tready && !out_load)
				m_valid_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (in_take) begin
						x0_q    <= s_tdata[SAMPLE_BITS-1:0];
						ch_q    <= ch_sel;
						state_q <= T_MAC;
					end
				end
				T_MAC: begin
					if (mac_done)
						state_q <= T_DIV;
				end
				T_DIV: begin
					if (div_done)
						state_q <= T_WB;
				end
				T_WB: begin
					// hold the result until the output register is free
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_data_q  <= quot;
						m_clip_q  <= clip;
						state_q   <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = DATA_W'(m_data_q);
	assign m_tuser  = m_clip_q;

	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_valid_q || m_tready))
		else $error("output register overwritten while holding a result");

	// the MAC finishes only while the sequencer waits for it
	a_mac_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == T_MAC))
		else $error("MAC completion outside the MAC phase");

	// the divider finishes only while the sequencer waits for it
	a_div_phase: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == T_DIV))
		else $error("divider completion outside the divide phase");

	// an accepted sample always starts the MAC on the first term
	a_mac_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (term == biq_pkg::TERM_B0) && (state_q == T_MAC))
		else $error("MAC not started on the first term");

endmodule
